// ===== rtl/qpr_pkg.sv =====
// ----------------------------------------------------------------------------
// qpr_pkg: shared types and constants for quaternion point rotation
// Beat payloads, coefficient matrix types, register indexes and the fixed
// widths of the multiply, sum and rounding stages.
// ----------------------------------------------------------------------------
`default_nettype none

package qpr_pkg;

    // Field widths
    localparam int QUAT_W  = 16;               // Q1.14 quaternion part
    localparam int COORD_W = 32;               // Q16.16 coordinate
    localparam int HALF_W  = COORD_W / 2;      // coordinate split into halves
    localparam int COEF_W  = 34;               // 2(bc - ad) needs 34 bits

    // Datapath widths of one matrix row
    localparam int PH_W   = COEF_W + HALF_W;       // coef * signed high half
    localparam int PL_W   = COEF_W + HALF_W + 1;   // coef * unsigned low half
    localparam int SH_W   = PH_W + 2;              // sum of three high products
    localparam int SL_W   = PL_W + 2;              // sum of three low products
    localparam int TOT_W  = SH_W + HALF_W + 2;     // full total plus round bit
    localparam int FRAC_SHIFT = 28;                // Q1.14 squared times Q16.16
    localparam int RES_W  = TOT_W - FRAC_SHIFT;    // rounded value before clamp
    localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    // Configuration register indexes
    localparam logic [1:0] REG_QUAT_W = 2'd0;
    localparam logic [1:0] REG_QUAT_X = 2'd1;
    localparam logic [1:0] REG_QUAT_Y = 2'd2;
    localparam logic [1:0] REG_QUAT_Z = 2'd3;

    localparam logic signed [QUAT_W-1:0] QUAT_ONE = 16'sd16384;

    typedef struct packed {
        logic signed [COORD_W-1:0] in_x;
        logic signed [COORD_W-1:0] in_y;
        logic signed [COORD_W-1:0] in_z;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] rot_x;
        logic signed [COORD_W-1:0] rot_y;
        logic signed [COORD_W-1:0] rot_z;
        logic                      clipped;
    } t_out;

    typedef struct packed {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
    } t_quat;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef t_coef [2:0]              t_row;
    typedef t_row  [2:0]              t_mat;

    typedef logic [HALF_W-1:0]        t_half;
    typedef t_half [2:0]              t_half3;

endpackage

`default_nettype wire

// ===== rtl/qpr_coef.sv =====
// ----------------------------------------------------------------------------
// qpr_coef: rotation matrix from the quaternion registers
// Two register stages: the ten pairwise products of q, then the nine
// matrix coefficients, exact and quadratic in q.
// ----------------------------------------------------------------------------
`default_nettype none

module qpr_coef import qpr_pkg::*; (
    input  logic  i_clk,
    input  t_quat i_quat,
    output t_mat  o_mat
);

    logic signed [2*QUAT_W-1:0] r_aa, r_bb, r_cc, r_dd;
    logic signed [2*QUAT_W-1:0] r_ab, r_ac, r_ad, r_bc, r_bd, r_cd;
    t_mat r_mat;

    logic signed [COEF_W-1:0] w_aa, w_bb, w_cc, w_dd;
    logic signed [COEF_W-1:0] w_ab, w_ac, w_ad, w_bc, w_bd, w_cd;

    always_ff @(posedge i_clk) begin
        r_aa <= i_quat.w * i_quat.w;
        r_bb <= i_quat.x * i_quat.x;
        r_cc <= i_quat.y * i_quat.y;
        r_dd <= i_quat.z * i_quat.z;
        r_ab <= i_quat.w * i_quat.x;
        r_ac <= i_quat.w * i_quat.y;
        r_ad <= i_quat.w * i_quat.z;
        r_bc <= i_quat.x * i_quat.y;
        r_bd <= i_quat.x * i_quat.z;
        r_cd <= i_quat.y * i_quat.z;
    end

    assign w_aa = COEF_W'(r_aa);
    assign w_bb = COEF_W'(r_bb);
    assign w_cc = COEF_W'(r_cc);
    assign w_dd = COEF_W'(r_dd);
    assign w_ab = COEF_W'(r_ab);
    assign w_ac = COEF_W'(r_ac);
    assign w_ad = COEF_W'(r_ad);
    assign w_bc = COEF_W'(r_bc);
    assign w_bd = COEF_W'(r_bd);
    assign w_cd = COEF_W'(r_cd);

    // Row index first, column index second
    always_ff @(posedge i_clk) begin
        r_mat[0][0] <= w_aa + w_bb - w_cc - w_dd;
        r_mat[0][1] <= (w_bc - w_ad) <<< 1;
        r_mat[0][2] <= (w_bd + w_ac) <<< 1;
        r_mat[1][0] <= (w_bc + w_ad) <<< 1;
        r_mat[1][1] <= w_aa - w_bb + w_cc - w_dd;
        r_mat[1][2] <= (w_cd - w_ab) <<< 1;
        r_mat[2][0] <= (w_bd - w_ac) <<< 1;
        r_mat[2][1] <= (w_cd + w_ab) <<< 1;
        r_mat[2][2] <= w_aa - w_bb - w_cc + w_dd;
    end

    assign o_mat = r_mat;

endmodule

`default_nettype wire

// ===== rtl/qpr_row.sv =====
// ----------------------------------------------------------------------------
// qpr_row: one output coordinate, three register stages
// Multiply each coefficient by the high and low halves of the point, sum the
// partial products, then round to nearest and clamp to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module qpr_row import qpr_pkg::*; (
    input  logic                      i_clk,
    input  t_row                      i_coef,
    input  t_half3                    i_hi,
    input  t_half3                    i_lo,
    output logic signed [COORD_W-1:0] o_coord,
    output logic                      o_clip
);

    logic signed [PH_W-1:0]    r_ph [3];
    logic signed [PL_W-1:0]    r_pl [3];
    logic signed [SH_W-1:0]    r_sh;
    logic signed [SL_W-1:0]    r_sl;
    logic signed [TOT_W-1:0]   w_tot;
    logic signed [RES_W-1:0]   w_res;
    logic                      w_over;
    logic                      w_under;
    logic signed [COORD_W-1:0] r_coord;
    logic                      r_clip;

    // Stage 1: partial products, 34x16 and 34x17
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_ph[j] <= $signed(i_coef[j]) * $signed(i_hi[j]);
            r_pl[j] <= $signed(i_coef[j]) * $signed({1'b0, i_lo[j]});
        end
    end

    // Stage 2: sum the three columns
    always_ff @(posedge i_clk) begin
        r_sh <= SH_W'(r_ph[0]) + SH_W'(r_ph[1]) + SH_W'(r_ph[2]);
        r_sl <= SL_W'(r_pl[0]) + SL_W'(r_pl[1]) + SL_W'(r_pl[2]);
    end

    // Stage 3: rejoin halves, round half up, clamp
    assign w_tot   = (TOT_W'(r_sh) <<< HALF_W) + TOT_W'(r_sl) + TOT_W'(ROUND_HALF);
    assign w_res   = $signed(w_tot[TOT_W-1:FRAC_SHIFT]);
    assign w_over  = !w_res[RES_W-1] && (|w_res[RES_W-2:COORD_W-1]);
    assign w_under = w_res[RES_W-1] && !(&w_res[RES_W-2:COORD_W-1]);

    always_ff @(posedge i_clk) begin
        if (w_over) begin
            r_coord <= COORD_MAX;
        end else if (w_under) begin
            r_coord <= COORD_MIN;
        end else begin
            r_coord <= w_res[COORD_W-1:0];
        end
        r_clip <= w_over || w_under;
    end

    assign o_coord = r_coord;
    assign o_clip  = r_clip;

endmodule

`default_nettype wire

// ===== rtl/quaternion_point_rotation.sv =====
// ----------------------------------------------------------------------------
// quaternion_point_rotation: rotate a Q16.16 point by a configured quaternion
// Computes the vector part of q * (0, v) * conj(q) through the exact 3x3
// matrix quadratic in q, rounds to nearest (ties up) and saturates.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                  Handshake
//  -------   -------------------------------------  --------------------------
//  input     start, busy, i_item (t_in)             beat on start && !busy
//  result    o_strobe, o_result (t_out)             beat on o_strobe, no stall
//  config    i_cfg_we, i_cfg_idx, i_cfg_data        write on i_cfg_we
//
//  Cycles: one beat per clock while busy is low; four register stages, the
//  input register, the multiply stage, the column sum stage and the
//  round/clamp stage. The result strobe rises as the round/clamp stage
//  registers the result, and the result is taken while the strobe is high.
//  Reset: synchronous, active low; clears the valid line and loads the
//  identity quaternion. busy is high during reset and in the cycle after it.
//  Stalls: none on the result side; input is held off while busy is high; the result strobe lasts one cycle.
//  A register write reaches the coefficient matrix through the quaternion
//  and product registers; busy is high for the cycle after each write, so
//  the first beat that can follow already meets the new matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_point_rotation import qpr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  t_in               i_item,
    output logic              busy,
    output logic              o_strobe,
    output t_out              o_result,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [QUAT_W-1:0] i_cfg_data
);

    t_quat      r_quat;
    logic       r_busy;
    logic [3:0] r_vld;
    t_in        r_in;
    logic       w_accept;
    t_mat       w_mat;
    t_half3     w_hi;
    t_half3     w_lo;

    logic signed [COORD_W-1:0] w_rot [3];
    logic                      w_clip [3];

    assign w_accept = start && !busy;

    // Configuration registers: hold unless written; an unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.w <= QUAT_ONE;
            r_quat.x <= '0;
            r_quat.y <= '0;
            r_quat.z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_QUAT_W: r_quat.w <= i_cfg_data;
                REG_QUAT_X: r_quat.x <= i_cfg_data;
                REG_QUAT_Y: r_quat.y <= i_cfg_data;
                REG_QUAT_Z: r_quat.z <= i_cfg_data;
                default:    r_quat   <= r_quat;
            endcase
        end
    end

    // Valid line: advance one stage per clock alongside the data.
    // Hold off input for one cycle after a register write while the new
    // coefficients travel to the matrix.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= i_cfg_we;
            r_vld  <= {r_vld[2:0], w_accept};
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_vld[3];

    // Input register: capture every clock, only valid beats reach the output
    always_ff @(posedge i_clk) begin
        r_in <= i_item;
    end

    // Split each coordinate into its signed high and unsigned low halves
    assign w_hi[0] = r_in.in_x[COORD_W-1:HALF_W];
    assign w_hi[1] = r_in.in_y[COORD_W-1:HALF_W];
    assign w_hi[2] = r_in.in_z[COORD_W-1:HALF_W];
    assign w_lo[0] = r_in.in_x[HALF_W-1:0];
    assign w_lo[1] = r_in.in_y[HALF_W-1:0];
    assign w_lo[2] = r_in.in_z[HALF_W-1:0];

    qpr_coef u_coef (
        .i_clk  (i_clk),
        .i_quat (r_quat),
        .o_mat  (w_mat)
    );

    for (genvar g = 0; g < 3; g++) begin : g_row
        qpr_row u_row (
            .i_clk   (i_clk),
            .i_coef  (w_mat[g]),
            .i_hi    (w_hi),
            .i_lo    (w_lo),
            .o_coord (w_rot[g]),
            .o_clip  (w_clip[g])
        );
    end

    assign o_result.rot_x   = w_rot[0];
    assign o_result.rot_y   = w_rot[1];
    assign o_result.rot_z   = w_rot[2];
    assign o_result.clipped = w_clip[0] || w_clip[1] || w_clip[2];

    // Every accepted beat yields exactly one strobe
    a_beat_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##4 o_strobe)
        else $error("accepted beat produced no result");

    a_result_from_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept && i_rst_n, 4))
        else $error("result without an accepted beat");

    // A clipped result must carry a clamped coordinate
    a_clip_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.clipped) |->
            (o_result.rot_x == COORD_MAX || o_result.rot_x == COORD_MIN ||
             o_result.rot_y == COORD_MAX || o_result.rot_y == COORD_MIN ||
             o_result.rot_z == COORD_MAX || o_result.rot_z == COORD_MIN))
        else $error("clipped flag without a saturated coordinate");

endmodule

`default_nettype wire
